>>> sv/plen_pkg.sv
// ----------------------------------------------------------------------------
// plen_pkg
// shared types and field widths for the positional list engine
// ----------------------------------------------------------------------------
package plen_pkg;

    // field widths of one request word and one result word
    localparam int ACT_W     = 3;
    localparam int VAL_W     = 32;
    localparam int POS_W     = 5;
    localparam int ST_W      = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // request actions
    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_INSERT_AT  = 3'd2,
        ACT_POP_FRONT  = 3'd3,
        ACT_POP_BACK   = 3'd4,
        ACT_DELETE_AT  = 3'd5,
        ACT_LIST       = 3'd6
    } action_t;

    // result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_INVALID = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

>>> sv/plen_mem.sv
// ----------------------------------------------------------------------------
// plen_mem
// entry store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module plen_mem
    import plen_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                    aclk,
    input  logic                    wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic signed [VAL_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic signed [VAL_W-1:0] rd_data
);

    logic signed [VAL_W-1:0] mem_reg [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/plen_ctrl.sv
// ----------------------------------------------------------------------------
// plen_ctrl
// request sequencer: checks, moves entries through the store, emits results
// ----------------------------------------------------------------------------
module plen_ctrl
    import plen_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // request side
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [ACT_W-1:0]        in_action,
    input  logic signed [VAL_W-1:0] in_value,
    input  logic [POS_W-1:0]        in_pos,
    // result side
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [ST_W-1:0]         out_status,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    out_last,
    // entry store
    output logic                    mem_wr_en,
    output logic [AW-1:0]           mem_wr_addr,
    output logic signed [VAL_W-1:0] mem_wr_data,
    output logic                    mem_rd_en,
    output logic [AW-1:0]           mem_rd_addr,
    input  logic signed [VAL_W-1:0] mem_rd_data,
    // fill level
    output logic [CW-1:0]           count
);

    localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_DN_RD,
        S_DN_WR,
        S_LIST_RD,
        S_LIST_WAIT,
        S_LIST_OUT,
        S_STATUS
    } state_t;

    state_t                  state_reg;
    logic [CW-1:0]           count_reg;
    logic [CW-1:0]           idx_reg;
    logic [CW-1:0]           tgt_reg;
    logic signed [VAL_W-1:0] val_reg;
    status_t                 st_reg;
    logic                    m_valid_reg;
    logic [ST_W-1:0]         m_status_reg;
    logic signed [VAL_W-1:0] m_value_reg;
    logic                    m_last_reg;

    logic          accept;
    logic          out_free;
    logic          load_word;
    logic [XW-1:0] pos_ext;
    logic [XW-1:0] cnt_ext;
    logic          full;
    logic          empty;
    logic          ins_ok;
    logic          del_ok;
    logic [CW-1:0] pos_idx;
    logic [CW-1:0] idx_m1;
    logic [CW-1:0] idx_p1;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_free  = !m_valid_reg || out_ready;
    assign load_word = out_free && ((state_reg == S_LIST_OUT) || (state_reg == S_STATUS));

    // position checks against the fill level
    assign pos_ext = XW'(in_pos);
    assign cnt_ext = XW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + XW'(1));
    assign del_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign pos_idx = CW'(pos_ext - XW'(1));
    assign idx_m1  = idx_reg - CW'(1);
    assign idx_p1  = idx_reg + CW'(1);

    // store access per state; reads and writes never share a cycle
    always_comb begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg[AW-1:0];
        mem_wr_data = mem_rd_data;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg[AW-1:0];
        unique case (state_reg)
            S_UP_RD: begin
                if (idx_reg == tgt_reg) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = val_reg;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_m1[AW-1:0];
                end
            end
            S_UP_WR: begin
                mem_wr_en = 1'b1;
            end
            S_DN_RD: begin
                if (idx_p1 != count_reg) begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_p1[AW-1:0];
                end
            end
            S_DN_WR: begin
                mem_wr_en = 1'b1;
            end
            S_LIST_RD: begin
                mem_rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // sequencer and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_word) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        val_reg <= in_value;
                        unique case (in_action)
                            ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
                                if (full) begin
                                    st_reg    <= ST_FULL;
                                    state_reg <= S_STATUS;
                                end else if (in_action == ACT_INSERT_AT && !ins_ok) begin
                                    st_reg    <= ST_INVALID;
                                    state_reg <= S_STATUS;
                                end else begin
                                    idx_reg <= count_reg;
                                    priority case (in_action)
                                        ACT_PUSH_FRONT: tgt_reg <= '0;
                                        ACT_PUSH_BACK:  tgt_reg <= count_reg;
                                        default:        tgt_reg <= pos_idx;
                                    endcase
                                    state_reg <= S_UP_RD;
                                end
                            end
                            ACT_POP_FRONT, ACT_POP_BACK, ACT_DELETE_AT: begin
                                if (empty) begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_STATUS;
                                end else if (in_action == ACT_DELETE_AT && !del_ok) begin
                                    st_reg    <= ST_INVALID;
                                    state_reg <= S_STATUS;
                                end else begin
                                    priority case (in_action)
                                        ACT_POP_FRONT: idx_reg <= '0;
                                        ACT_POP_BACK:  idx_reg <= count_reg - CW'(1);
                                        default:       idx_reg <= pos_idx;
                                    endcase
                                    state_reg <= S_DN_RD;
                                end
                            end
                            ACT_LIST: begin
                                idx_reg <= '0;
                                if (empty) begin
                                    st_reg    <= ST_EMPTY;
                                    state_reg <= S_STATUS;
                                end else begin
                                    state_reg <= S_LIST_RD;
                                end
                            end
                            default: begin
                                st_reg    <= ST_INVALID;
                                state_reg <= S_STATUS;
                            end
                        endcase
                    end
                end
                // open the gap from the tail down, then drop the value in
                S_UP_RD: begin
                    if (idx_reg == tgt_reg) begin
                        count_reg <= count_reg + CW'(1);
                        st_reg    <= ST_OK;
                        state_reg <= S_STATUS;
                    end else begin
                        state_reg <= S_UP_WR;
                    end
                end
                S_UP_WR: begin
                    idx_reg   <= idx_m1;
                    state_reg <= S_UP_RD;
                end
                // close the gap from the hole up to the tail
                S_DN_RD: begin
                    if (idx_p1 == count_reg) begin
                        count_reg <= count_reg - CW'(1);
                        st_reg    <= ST_OK;
                        state_reg <= S_STATUS;
                    end else begin
                        state_reg <= S_DN_WR;
                    end
                end
                S_DN_WR: begin
                    idx_reg   <= idx_p1;
                    state_reg <= S_DN_RD;
                end
                // walk the list, one word per entry
                S_LIST_RD: begin
                    state_reg <= S_LIST_WAIT;
                end
                S_LIST_WAIT: begin
                    state_reg <= S_LIST_OUT;
                end
                S_LIST_OUT: begin
                    if (out_free) begin
                        m_status_reg <= ST_OK;
                        m_value_reg  <= mem_rd_data;
                        m_last_reg   <= (idx_p1 == count_reg);
                        idx_reg      <= idx_p1;
                        state_reg    <= (idx_p1 == count_reg) ? S_IDLE : S_LIST_RD;
                    end
                end
                // single status word
                S_STATUS: begin
                    if (out_free) begin
                        m_status_reg <= st_reg;
                        m_value_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_value  = m_value_reg;
    assign out_last   = m_last_reg;
    assign count      = count_reg;

endmodule

>>> sv/positional_list_engine_unit.sv
// steps: insert moves the entries from the tail down to the position one place toward
//   the tail, delete moves those above the hole one place toward the head
// throughput: one request at a time; a listing runs the read, wait and emit steps per
//   entry, emit stalling while a result word is held; moves take one read and one write per entry
// reset: synchronous active-low aresetn empties the list and drops any pending word;
//   store contents are left as they were and are only read below the fill level
// ----------------------------------------------------------------------------
// positional_list_engine_unit
// bounded ordered list of signed values with insert, delete and list requests
// ----------------------------------------------------------------------------
module positional_list_engine_unit
    import plen_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // action[2:0], value_in[34:3], position[39:35]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // status[1:0], value_out[33:2], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic                    mem_wr_en;
    logic [AW-1:0]           mem_wr_addr;
    logic signed [VAL_W-1:0] mem_wr_data;
    logic                    mem_rd_en;
    logic [AW-1:0]           mem_rd_addr;
    logic signed [VAL_W-1:0] mem_rd_data;
    logic [ST_W-1:0]         out_status;
    logic signed [VAL_W-1:0] out_value;
    logic [CW-1:0]           count;

    // sequencer
    plen_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_action   (s_tdata[ACT_W-1:0]),
        .in_value    (s_tdata[ACT_W+VAL_W-1:ACT_W]),
        .in_pos      (s_tdata[ACT_W+VAL_W+POS_W-1:ACT_W+VAL_W]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_status  (out_status),
        .out_value   (out_value),
        .out_last    (m_tlast),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data),
        .count       (count)
    );

    // entry store
    plen_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // pack the result word
    assign m_tdata = {{(M_TDATA_W - ST_W - VAL_W){1'b0}}, out_value, out_status};

`ifndef SYNTHESIS
    // fill level never passes the depth
    assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CW'(DEPTH))
    else $error("list count exceeds depth");

    // one request in flight: no accept right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous one still in flight");

    // store port sees a read or a write, never both
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(mem_wr_en && mem_rd_en))
    else $error("store read and write in the same cycle");

    // fill level moves by at most one per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $past(count) != count) |->
        (count == $past(count) + CW'(1) || count + CW'(1) == $past(count)))
    else $error("list count jumped");
`endif

endmodule

>>> tb/sv/positional_list_engine_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_tb
// self-checking bench for the bounded ordered list engine: a shadow list
// tracks every accepted request word and predicts each result word, which is
// compared field by field as it leaves the block; both stream sides idle at
// random and the result side holds off once for a long stretch
// ----------------------------------------------------------------------------
module positional_list_engine_unit_tb;
    import plen_pkg::*;

    localparam int DEPTH        = 16;
    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 120;
    localparam int RANDOM_ITEMS = 480;
    localparam int HOLD_AT_WORD = 150;
    localparam int HOLD_CYCLES  = 400;

    // action code outside the defined set
    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;

    typedef struct {
        status_t                 status;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } result_word_t;

    // shadow list and queue of result words still owed by the block
    class list_scoreboard;
        logic signed [VAL_W-1:0] shadow_list[$];
        result_word_t            owed_words[$];
        int unsigned             error_count;

        function int unsigned fill();
            return shadow_list.size();
        endfunction

        function int unsigned waiting();
            return owed_words.size();
        endfunction

        function void owe_status(status_t st);
            result_word_t w;
            w.status = st;
            w.value  = '0;
            w.last   = 1'b1;
            owed_words.push_back(w);
        endfunction

        // apply one accepted request to the shadow list
        function void note_request(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
                                   logic [POS_W-1:0] pos);
            int n;
            result_word_t w;
            n = shadow_list.size();
            case (act)
                ACT_PUSH_FRONT, ACT_PUSH_BACK, ACT_INSERT_AT: begin
                    // full is checked ahead of the position
                    if (n >= DEPTH) begin
                        owe_status(ST_FULL);
                    end else if (act == ACT_PUSH_FRONT) begin
                        shadow_list.push_front(val);
                        owe_status(ST_OK);
                    end else if (act == ACT_PUSH_BACK) begin
                        shadow_list.push_back(val);
                        owe_status(ST_OK);
                    end else if (pos < 1 || int'(pos) > n + 1) begin
                        owe_status(ST_INVALID);
                    end else begin
                        shadow_list.insert(int'(pos) - 1, val);
                        owe_status(ST_OK);
                    end
                end
                ACT_POP_FRONT, ACT_POP_BACK, ACT_DELETE_AT: begin
                    if (n == 0) begin
                        owe_status(ST_EMPTY);
                    end else if (act == ACT_POP_FRONT) begin
                        void'(shadow_list.pop_front());
                        owe_status(ST_OK);
                    end else if (act == ACT_POP_BACK) begin
                        void'(shadow_list.pop_back());
                        owe_status(ST_OK);
                    end else if (pos < 1 || int'(pos) > n) begin
                        owe_status(ST_INVALID);
                    end else begin
                        shadow_list.delete(int'(pos) - 1);
                        owe_status(ST_OK);
                    end
                end
                ACT_LIST: begin
                    if (n == 0) begin
                        owe_status(ST_EMPTY);
                    end else begin
                        foreach (shadow_list[k]) begin
                            w.status = ST_OK;
                            w.value  = shadow_list[k];
                            w.last   = (k == n - 1);
                            owed_words.push_back(w);
                        end
                    end
                end
                default: begin
                    owe_status(ST_INVALID);
                end
            endcase
        endfunction

        // compare one result word with the oldest one owed
        function void check_word(status_t st, logic signed [VAL_W-1:0] val, logic lst);
            result_word_t w;
            if (owed_words.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result word status=%0d value=%0d last=%0b",
                         $time, st, val, lst);
                return;
            end
            w = owed_words.pop_front();
            if (st !== w.status) begin
                error_count++;
                $display("%0t: status mismatch expected=%0d actual=%0d",
                         $time, w.status, st);
            end
            if (val !== w.value) begin
                error_count++;
                $display("%0t: value mismatch expected=%0d actual=%0d",
                         $time, w.value, val);
            end
            if (lst !== w.last) begin
                error_count++;
                $display("%0t: last mismatch expected=%0b actual=%0b",
                         $time, w.last, lst);
            end
        endfunction
    endclass

    logic                 aclk;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // action[2:0], value_in[34:3], position[39:35]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // status[1:0], value_out[33:2], zero fill above
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    list_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    send_calm   = 0;
    int unsigned    recv_calm   = 0;

    positional_list_engine_unit #(
        .DEPTH(DEPTH)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // idle cycles before the next word, with occasional stretches of none
    function automatic int unsigned draw_wait(ref int unsigned calm_left);
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // data values with the extremes mixed in
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // offer one request word and hold it until accepted
    task automatic send_request(logic [ACT_W-1:0] act, logic signed [VAL_W-1:0] val,
                                logic [POS_W-1:0] pos);
        int unsigned gap;
        gap = draw_wait(send_calm);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pos, val, act};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(act, val, pos);
    endtask

    // corner cases: empty list, bad positions, extremes, full list
    task automatic run_directed();
        send_request(ACT_LIST, pick_value(), 5'd0);
        send_request(ACT_POP_FRONT, pick_value(), 5'd1);
        send_request(ACT_POP_BACK, pick_value(), 5'd1);
        send_request(ACT_DELETE_AT, pick_value(), 5'd1);
        send_request(ACT_INSERT_AT, 32'h1234_5678, 5'd0);
        send_request(ACT_INSERT_AT, 32'h1234_5678, 5'd2);
        send_request(ACT_INSERT_AT, 32'h7fff_ffff, 5'd1);
        send_request(ACT_PUSH_FRONT, 32'h8000_0000, 5'd17);
        send_request(ACT_PUSH_BACK, 32'hffff_ffff, 5'd31);
        send_request(ACT_INSERT_AT, 32'h0000_0000, 5'd4);
        send_request(ACT_INSERT_AT, 32'h5555_5555, 5'd2);
        send_request(ACT_INSERT_AT, 32'h2222_2222, 5'd7);
        send_request(ACT_DELETE_AT, pick_value(), 5'd0);
        send_request(ACT_DELETE_AT, pick_value(), 5'd6);
        send_request(ACT_DELETE_AT, pick_value(), 5'd3);
        send_request(ACT_UNUSED, pick_value(), 5'd1);
        send_request(ACT_LIST, pick_value(), 5'd0);
        while (sb.fill() < DEPTH) begin
            send_request(ACT_PUSH_BACK, $urandom, POS_W'($urandom_range(0, 17)));
        end
        send_request(ACT_PUSH_FRONT, 32'h3333_3333, 5'd1);
        send_request(ACT_PUSH_BACK, 32'h4444_4444, 5'd1);
        send_request(ACT_INSERT_AT, 32'h6666_6666, 5'd17);
        send_request(ACT_LIST, pick_value(), 5'd0);
        send_request(ACT_DELETE_AT, pick_value(), 5'd16);
        send_request(ACT_POP_FRONT, pick_value(), 5'd0);
        send_request(ACT_POP_BACK, pick_value(), 5'd0);
    endtask

    // random requests in phases biased toward growing, shrinking or mixed
    task automatic run_random(int unsigned items);
        int unsigned      n;
        int unsigned      r;
        int unsigned      ins_share;
        logic [ACT_W-1:0] act;
        logic [VAL_W-1:0] val;
        logic [POS_W-1:0] pos;
        ins_share = 45;
        for (int unsigned i = 0; i < items; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0:       ins_share = 70;
                    1:       ins_share = 25;
                    default: ins_share = 46;
                endcase
            end
            n   = sb.fill();
            r   = $urandom_range(0, 99);
            val = pick_value();
            pos = POS_W'($urandom_range(0, 17));
            if (r < ins_share) begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_PUSH_FRONT;
                    1:       act = ACT_PUSH_BACK;
                    default: act = ACT_INSERT_AT;
                endcase
                if (act == ACT_INSERT_AT && $urandom_range(0, 7) != 0) begin
                    pos = POS_W'($urandom_range(1, n + 1));
                end
            end else if (r < 92) begin
                case ($urandom_range(0, 2))
                    0:       act = ACT_POP_FRONT;
                    1:       act = ACT_POP_BACK;
                    default: act = ACT_DELETE_AT;
                endcase
                if (act == ACT_DELETE_AT && n > 0 && $urandom_range(0, 7) != 0) begin
                    pos = POS_W'($urandom_range(1, n));
                end
            end else if (r < 99) begin
                act = ACT_LIST;
            end else begin
                act = ACT_UNUSED;
            end
            send_request(act, val, pos);
        end
    endtask

    // main sequence
    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        run_random(RANDOM_ITEMS);
        s_tvalid <= 1'b0;
        while (sb.waiting() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // result side: random ready gaps and one long hold-off
    initial begin
        int unsigned gap;
        int unsigned words_taken;
        words_taken = 0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            gap = draw_wait(recv_calm);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            words_taken++;
            if (words_taken == HOLD_AT_WORD) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
        end
    end

    // check each accepted result word
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(status_t'(m_tdata[ST_W-1:0]),
                          $signed(m_tdata[ST_W+VAL_W-1:ST_W]), m_tlast);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d result words outstanding", $time, sb.waiting());
            $display("status: fail");
            $finish;
        end
    end

endmodule

>>> filelist.f
sv/plen_pkg.sv
sv/plen_mem.sv
sv/plen_ctrl.sv
sv/positional_list_engine_unit.sv
tb/sv/positional_list_engine_unit_tb.sv
